// ===== rtl/qrs_pkg.sv =====
// Shared types, widths and codes for the quadratic root solver.
// No dependencies; every other rtl file imports this package.
package qrs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int COEF_W    = 32;
    // Discriminant b*b - 4ac, signed, exact.
    localparam int D_W       = 2 * COEF_W + 2;
    // floor(sqrt(D)) width and the sqrt trial width.
    localparam int ROOT_W    = D_W / 2 + 1;
    localparam int SQ_W      = 2 * ROOT_W;
    // Numerator -b +/- s, signed, and its magnitude.
    localparam int NUM_W     = ROOT_W + 1;
    localparam int MAG_W     = ROOT_W;
    // Divisor 2|a| and the scaled dividend.
    localparam int DEN_W     = COEF_W + 1;
    localparam int DVD_W     = MAG_W + FRAC_BITS;
    // Queue between front and back.
    localparam int Q_DEPTH   = 4;
    localparam int QPTR_W    = $clog2(Q_DEPTH);
    localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
    // Items the front may still push after busy rises.
    localparam int FRONT_INFLIGHT = 3;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_AZERO = 2'd1,
        ST_NEG   = 2'd2
    } status_t;

    // Per-item side data carried beside the datapath.
    typedef struct packed {
        status_t                    status;
        logic signed [COEF_W-1:0]   coef_a;
        logic signed [COEF_W-1:0]   coef_b;
    } side_t;

    // Queue word from front to back.
    typedef struct packed {
        side_t                      side;
        logic signed [D_W-1:0]      disc;
    } qitem_t;

endpackage

// ===== rtl/qrs_front.sv =====
// Front end: accepts a coefficient triple, forms b*b and a*c, then the
// discriminant and status, and pushes one queue word. Uses qrs_pkg.
module qrs_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              push,
    output qrs_pkg::qitem_t                   push_word
);
    import qrs_pkg::*;

    logic                        v1_reg;
    logic signed [COEF_W-1:0]    a1_reg;
    logic signed [COEF_W-1:0]    b1_reg;
    logic [2*COEF_W-1:0]         bb1_reg;
    logic signed [2*COEF_W-1:0]  ac1_reg;
    logic [COEF_W-1:0]           babs;
    logic [2*COEF_W-1:0]         bb_next;
    logic signed [2*COEF_W-1:0]  ac_next;
    logic signed [D_W-1:0]       disc_next;
    status_t                     status_next;
    logic                        push_reg;
    qitem_t                      word_reg;

    // Stage 1: the two products
    assign babs    = coef_b[COEF_W-1] ? (~coef_b + 1'b1) : coef_b;
    assign bb_next = babs * babs;
    assign ac_next = coef_a * coef_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            push_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            push_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a1_reg          <= coef_a;
        b1_reg          <= coef_b;
        bb1_reg         <= bb_next;
        ac1_reg         <= ac_next;
        word_reg.side   <= '{status: status_next, coef_a: a1_reg, coef_b: b1_reg};
        word_reg.disc   <= disc_next;
    end

    // Stage 2: discriminant and classification
    assign disc_next = $signed({2'b00, bb1_reg}) - $signed({ac1_reg, 2'b00});

    always_comb
    begin
        priority if (a1_reg == '0)
            status_next = ST_AZERO;
        else if (disc_next[D_W-1])
            status_next = ST_NEG;
        else
            status_next = ST_OK;
    end

    assign push      = push_reg;
    assign push_word = word_reg;

endmodule

// ===== rtl/qrs_queue.sv =====
// Short queue between front and back ends, with an early busy flag.
// Uses qrs_pkg.
module qrs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  qrs_pkg::qitem_t push_word,
    input  logic            pop,
    output logic            not_empty,
    output qrs_pkg::qitem_t pop_word,
    output logic            near_full
);
    import qrs_pkg::*;

    qitem_t              mem_reg [0:Q_DEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_word;
    end

    // Pointers and fill count
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    assign not_empty = (count_reg != '0);
    assign pop_word  = mem_reg[rd_ptr_reg];
    // Room must remain for every word the front may still deliver.
    assign near_full = (count_reg > QCNT_W'(Q_DEPTH - FRONT_INFLIGHT));

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != QCNT_W'(Q_DEPTH))
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue pop while empty");
`endif

endmodule

// ===== rtl/qrs_sqrt.sv =====
// Pipelined floor square root of the discriminant, one root bit per stage.
// Uses qrs_pkg.
module qrs_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  qrs_pkg::qitem_t              in_word,
    output logic                         out_valid,
    output qrs_pkg::side_t               out_side,
    output logic [qrs_pkg::ROOT_W-1:0]   out_root
);
    import qrs_pkg::*;

    logic               v_reg    [0:ROOT_W-1];
    side_t              side_reg [0:ROOT_W-1];
    logic [D_W-1:0]     rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0]  root_reg [0:ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        localparam int K = ROOT_W - 1 - i;
        logic              cur_v;
        side_t             cur_side;
        logic [D_W-1:0]    cur_rem;
        logic [ROOT_W-1:0] cur_root;
        logic [SQ_W-1:0]   trial;
        logic [SQ_W-1:0]   rem_wide;
        logic              take;

        if (i == 0)
        begin : g_first
            assign cur_v    = in_valid;
            assign cur_side = in_word.side;
            assign cur_rem  = in_word.disc;
            assign cur_root = '0;
        end
        else
        begin : g_next
            assign cur_v    = v_reg[i-1];
            assign cur_side = side_reg[i-1];
            assign cur_rem  = rem_reg[i-1];
            assign cur_root = root_reg[i-1];
        end

        // (r + 2^k)^2 - r^2 = r*2^(k+1) + 2^(2k); r has no bits at or below k
        assign trial    = (SQ_W'(cur_root) << (K + 1)) | (SQ_W'(1) << (2 * K));
        assign rem_wide = SQ_W'(cur_rem);
        assign take     = (rem_wide >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else
                v_reg[i] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            side_reg[i] <= cur_side;
            rem_reg[i]  <= take ? D_W'(rem_wide - trial) : cur_rem;
            root_reg[i] <= take ? (cur_root | (ROOT_W'(1) << K)) : cur_root;
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

// ===== rtl/qrs_div.sv =====
// Two-lane pipelined restoring divider: num / (2a) scaled by FRAC_BITS,
// truncated toward zero and saturated to 32 bits. Uses qrs_pkg.
module qrs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  qrs_pkg::side_t                    in_side,
    input  logic signed [qrs_pkg::NUM_W-1:0]  num_plus,
    input  logic signed [qrs_pkg::NUM_W-1:0]  num_minus,
    output logic                              out_valid,
    output qrs_pkg::status_t                  out_status,
    output logic signed [qrs_pkg::COEF_W-1:0] out_plus,
    output logic signed [qrs_pkg::COEF_W-1:0] out_minus
);
    import qrs_pkg::*;

    logic                           pv_reg;
    status_t                        pst_reg;
    logic [1:0]                     pneg_reg;
    logic [1:0]                     pzero_reg;
    logic [1:0][DVD_W-1:0]          pdq_reg;
    logic [DEN_W-1:0]               pden_reg;
    logic signed [1:0][NUM_W-1:0]   num;
    logic [COEF_W-1:0]              a_abs;

    logic                           v_reg    [0:DVD_W-1];
    status_t                        st_reg   [0:DVD_W-1];
    logic [1:0]                     neg_reg  [0:DVD_W-1];
    logic [1:0]                     zero_reg [0:DVD_W-1];
    logic [DEN_W-1:0]               den_reg  [0:DVD_W-1];
    logic [1:0][DVD_W-1:0]          dq_reg   [0:DVD_W-1];
    logic [1:0][DEN_W-1:0]          rem_reg  [0:DVD_W-1];

    logic                           ov_reg;
    status_t                        ost_reg;
    logic [1:0][COEF_W-1:0]         oroot_reg;
    logic [1:0][COEF_W-1:0]         root_next;

    // Prep: sign, magnitude and divisor
    assign num[0] = num_plus;
    assign num[1] = num_minus;
    assign a_abs  = in_side.coef_a[COEF_W-1] ? (~in_side.coef_a + 1'b1) : in_side.coef_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        pst_reg  <= in_side.status;
        pden_reg <= {a_abs, 1'b0};
        for (int l = 0; l < 2; l++)
        begin
            pneg_reg[l]  <= num[l][NUM_W-1] ^ in_side.coef_a[COEF_W-1];
            pzero_reg[l] <= (num[l] == '0);
            pdq_reg[l]   <= {MAG_W'(num[l][NUM_W-1] ? -num[l] : num[l]),
                             {FRAC_BITS{1'b0}}};
        end
    end

    // One quotient bit per stage; dividend shifts out as quotient shifts in
    for (genvar j = 0; j < DVD_W; j++)
    begin : g_stage
        logic                   cur_v;
        status_t                cur_st;
        logic [1:0]             cur_neg;
        logic [1:0]             cur_zero;
        logic [DEN_W-1:0]       cur_den;
        logic [1:0][DVD_W-1:0]  cur_dq;
        logic [1:0][DEN_W-1:0]  cur_rem;
        logic [1:0][DEN_W:0]    trial;
        logic [1:0]             ge;

        if (j == 0)
        begin : g_first
            assign cur_v    = pv_reg;
            assign cur_st   = pst_reg;
            assign cur_neg  = pneg_reg;
            assign cur_zero = pzero_reg;
            assign cur_den  = pden_reg;
            assign cur_dq   = pdq_reg;
            assign cur_rem  = '0;
        end
        else
        begin : g_next
            assign cur_v    = v_reg[j-1];
            assign cur_st   = st_reg[j-1];
            assign cur_neg  = neg_reg[j-1];
            assign cur_zero = zero_reg[j-1];
            assign cur_den  = den_reg[j-1];
            assign cur_dq   = dq_reg[j-1];
            assign cur_rem  = rem_reg[j-1];
        end

        for (genvar l = 0; l < 2; l++)
        begin : g_lane
            assign trial[l] = {cur_rem[l], cur_dq[l][DVD_W-1]};
            assign ge[l]    = (trial[l] >= {1'b0, cur_den});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[j] <= 1'b0;
            else
                v_reg[j] <= cur_v;
        end

        always_ff @(posedge clk)
        begin
            st_reg[j]   <= cur_st;
            neg_reg[j]  <= cur_neg;
            zero_reg[j] <= cur_zero;
            den_reg[j]  <= cur_den;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[j][l] <= ge[l] ? DEN_W'(trial[l] - {1'b0, cur_den})
                                       : DEN_W'(trial[l]);
                dq_reg[j][l]  <= {cur_dq[l][DVD_W-2:0], ge[l]};
            end
        end
    end

    // Sign, saturation and forced zeros
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            logic [DVD_W-1:0] q;
            logic             big;
            q   = dq_reg[DVD_W-1][l];
            big = |q[DVD_W-1:COEF_W-1];
            if (st_reg[DVD_W-1] != ST_OK || zero_reg[DVD_W-1][l])
                root_next[l] = '0;
            else if (neg_reg[DVD_W-1][l])
                root_next[l] = big ? {1'b1, {(COEF_W-1){1'b0}}} : -q[COEF_W-1:0];
            else
                root_next[l] = big ? {1'b0, {(COEF_W-1){1'b1}}} : q[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= v_reg[DVD_W-1];
    end

    always_ff @(posedge clk)
    begin
        ost_reg   <= st_reg[DVD_W-1];
        oroot_reg <= root_next;
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_plus   = oroot_reg[0];
    assign out_minus  = oroot_reg[1];

endmodule

// ===== rtl/quadratic_root_solver.sv =====
// Top level of the quadratic root solver: front end, queue, square root,
// numerator stage and divider. Uses qrs_pkg and all rtl/qrs_* modules.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------
//  input    | start, busy         | coef_a, coef_b, coef_c
//  result   | done (one cycle)    | status, root_plus, root_minus
//
// One triple is taken per cycle while busy is low; each result comes out
// of the last register in the chain: 2 front stages, 1 queue stage,
// 34 square-root stages (one root bit each), 1 numerator stage and 52
// divider stages (prep, 50 quotient bits, output).
// Reset clears only the valid flags of the pipeline and the queue pointers and count.
// The result side has no stall and the back end pops whenever the queue is
// not empty, so the queue never holds more than one word and busy stays low.
module quadratic_root_solver (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_a,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_b,
    input  logic signed [qrs_pkg::COEF_W-1:0] coef_c,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [qrs_pkg::COEF_W-1:0] root_plus,
    output logic signed [qrs_pkg::COEF_W-1:0] root_minus
);
    import qrs_pkg::*;

    logic                       push;
    qitem_t                     push_word;
    logic                       not_empty;
    qitem_t                     pop_word;
    logic                       near_full;
    logic                       sq_valid;
    side_t                      sq_side;
    logic [ROOT_W-1:0]          sq_root;
    logic                       nv_reg;
    side_t                      nside_reg;
    logic signed [NUM_W-1:0]    nplus_reg;
    logic signed [NUM_W-1:0]    nminus_reg;
    logic signed [NUM_W-1:0]    b_ext;
    logic signed [NUM_W-1:0]    s_ext;
    status_t                    res_status;

    qrs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (start && !busy),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .push      (push),
        .push_word (push_word)
    );

    qrs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (not_empty),
        .not_empty (not_empty),
        .pop_word  (pop_word),
        .near_full (near_full)
    );

    qrs_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (not_empty),
        .in_word   (pop_word),
        .out_valid (sq_valid),
        .out_side  (sq_side),
        .out_root  (sq_root)
    );

    // Numerators -b + s and -b - s
    assign b_ext = NUM_W'(sq_side.coef_b);
    assign s_ext = $signed({1'b0, sq_root});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= 1'b0;
        else
            nv_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        nside_reg  <= sq_side;
        nplus_reg  <= s_ext - b_ext;
        nminus_reg <= -b_ext - s_ext;
    end

    qrs_div u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (nv_reg),
        .in_side    (nside_reg),
        .num_plus   (nplus_reg),
        .num_minus  (nminus_reg),
        .out_valid  (done),
        .out_status (res_status),
        .out_plus   (root_plus),
        .out_minus  (root_minus)
    );

    assign busy   = near_full;
    assign status = res_status;

`ifndef SYNTH
    a_fail_zero_roots: assert property (@(posedge clk) disable iff (!rst_n)
        done && res_status != ST_OK |-> root_plus == '0 && root_minus == '0)
        else $error("nonzero root on failed status");
`endif

endmodule
